[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/dpm_pkg.sv]
// ----------------------------------------------------------------------------
// dpm_pkg
// Shared constants and types of the demand paging MMU.
// ----------------------------------------------------------------------------
package dpm_pkg;
  localparam int NUM_FRAMES_DEF    = 256;
  localparam int PAGE_WORDS        = 4;
  localparam int OFF_W             = 2;
  localparam int PAGES_PER_PROCESS = 32;
  localparam int PG_W              = 5;
  localparam int MAX_PROCESSES     = 32;
  localparam int PID_W             = 5;
  localparam int TBL_AW            = PID_W + PG_W;
  localparam int STAMP_W           = 32;

  localparam logic MODE_XLATE  = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;
endpackage

[hdl/dpm_ram.sv]
// ----------------------------------------------------------------------------
// dpm_ram
// Page table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dpm_ram import dpm_pkg::*; #(
  parameter int DATA_W = 41
) (
  input  logic              clk,
  input  tbl_req_t          req,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [2**TBL_AW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

[hdl/demand_paging_mmu_lru_top.sv]
// ----------------------------------------------------------------------------
// demand_paging_mmu_lru_top
// Demand paging MMU with per-process page tables and LRU replacement.
// ----------------------------------------------------------------------------
// After reset the page table is swept clear, one entry a cycle, before the
// first beat is taken. One beat is handled at a time by a small sequencer
// around the table RAM (one registered read a step), the frame valid bits
// and the per-process frame counts. A hit reads the table (LK_RD, LK_CHK)
// before its result; an unpaged access goes straight to the result. A release
// reads the process's pages in turn (REL_RD, REL_CHK), one result beat per
// mapped page, until its frame count or its last page is reached. A fault
// scans frame valid bits one a cycle; with no free frame it then walks the 32
// frame counts and reads the victim process's 32 pages to find the oldest.
// The result register holds each result beat until taken.
module demand_paging_mmu_lru_top import dpm_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] process_id, [11:5] word_index, [21:12] ram_base
  input  logic [23:0] in_tdata,
  // [0] mode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] phys_address, [10] fault, [11] evicted, [16:12] victim_process,
  // [21:17] victim_page, [29:22] victim_frame
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int FW     = $clog2(NUM_FRAMES);
  localparam int CW     = $clog2(NUM_FRAMES + 1);
  localparam int DATA_W = 1 + FW + STAMP_W;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_REL_RD, ST_REL_CHK, ST_LK_RD, ST_LK_CHK, ST_FS,
    ST_MX, ST_LR_RD, ST_LR_CHK, ST_EVICT, ST_LOAD, ST_OUT
  } state_t;

  state_t                state_r;
  logic [TBL_AW-1:0]     clr_r;
  logic                  en_r;
  logic [NUM_FRAMES-1:0] fv_r;
  logic [CW-1:0]         cnt_r [MAX_PROCESSES];

  logic                  rel_r;
  logic [PID_W-1:0]      pid_r;
  logic [PG_W-1:0]       page_r;
  logic [OFF_W-1:0]      off_r;
  logic [STAMP_W-1:0]    clk_cnt_r;
  logic [FW-1:0]         fi_r;
  logic [PID_W-1:0]      pi_r;
  logic [PG_W-1:0]       pg_r;
  logic [CW-1:0]         best_r;
  logic [PID_W-1:0]      bestp_r;
  logic                  have_r;
  logic [STAMP_W-1:0]    old_age_r;
  logic [PG_W-1:0]       old_pg_r;
  logic [FW-1:0]         old_fr_r;
  logic [FW-1:0]         f_r;

  logic [9:0]            o_phys_r;
  logic                  o_fault_r, o_ev_r, o_last_r;
  logic [PID_W-1:0]      o_vp_r;
  logic [PG_W-1:0]       o_vpg_r;
  logic [7:0]            o_vf_r;

  // table RAM
  tbl_req_t              req;
  logic [DATA_W-1:0]     wdata, rdata;
  logic                  rd_valid;
  logic [FW-1:0]         rd_frame;
  logic [STAMP_W-1:0]    rd_stamp, age;
  logic [PID_W-1:0]      cnt_idx;
  logic [CW-1:0]         cnt_cur;

  assign rd_valid = rdata[DATA_W-1];
  assign rd_frame = rdata[STAMP_W +: FW];
  assign rd_stamp = rdata[STAMP_W-1:0];
  assign age      = clk_cnt_r - rd_stamp;   // wraps mod 2^32, larger is older

  dpm_ram #(.DATA_W(DATA_W)) u_ram (
    .clk   (clk),
    .req   (req),
    .wdata (wdata),
    .rdata (rdata)
  );

  // single count port, index chosen by the step in hand
  always_comb begin
    unique case (state_r)
      ST_MX:    cnt_idx = pi_r;
      ST_EVICT: cnt_idx = bestp_r;
      default:  cnt_idx = pid_r;
    endcase
  end
  assign cnt_cur = cnt_r[cnt_idx];

  always_comb begin
    req.we    = 1'b0;
    req.waddr = {pid_r, page_r};
    req.raddr = {pid_r, page_r};
    wdata     = '0;
    unique case (state_r)
      ST_CLR: begin
        req.we    = 1'b1;
        req.waddr = clr_r;
      end
      ST_REL_RD:  req.raddr = {pid_r, pg_r};
      ST_REL_CHK: begin
        req.we    = rd_valid;
        req.waddr = {pid_r, pg_r};
      end
      ST_LK_CHK: begin
        req.we = rd_valid;
        wdata  = {1'b1, rd_frame, clk_cnt_r};
      end
      ST_LR_RD:   req.raddr = {bestp_r, pg_r};
      ST_EVICT: begin
        req.we    = 1'b1;
        req.waddr = {bestp_r, old_pg_r};
      end
      ST_LOAD: begin
        req.we = 1'b1;
        wdata  = {1'b1, f_r, clk_cnt_r};
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_vf_r, o_vpg_r, o_vp_r, o_ev_r, o_fault_r, o_phys_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, en_r};

  logic            cfg_wr;
  logic [PG_W+6:0] xl_page;
  assign cfg_wr  = cfg_psel & cfg_penable & cfg_pwrite & ~cfg_paddr[2];
  assign xl_page = {5'd0, in_tdata[11:5]} >> OFF_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_r     <= '0;
      en_r      <= 1'b1;
      fv_r      <= '0;
      clk_cnt_r <= '0;
      for (int k = 0; k < MAX_PROCESSES; k++) cnt_r[k] <= '0;
    end else begin
      if (cfg_wr) begin
        en_r <= cfg_pwdata[0];
      end
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            rel_r     <= (in_tuser == MODE_RELEASE);
            pid_r     <= in_tdata[4:0];
            page_r    <= PG_W'(xl_page);
            off_r     <= in_tdata[5 +: OFF_W];
            pg_r      <= '0;
            o_fault_r <= 1'b0;
            o_ev_r    <= 1'b0;
            o_vp_r    <= '0;
            o_vpg_r   <= '0;
            o_vf_r    <= '0;
            o_last_r  <= 1'b1;
            o_phys_r  <= in_tdata[21:12] + 10'(in_tdata[11:5]);
            if (in_tuser == MODE_RELEASE) begin
              state_r <= ST_REL_RD;
            end else if (!en_r) begin
              state_r <= ST_OUT;
            end else begin
              clk_cnt_r <= clk_cnt_r + 1'b1;
              state_r   <= ST_LK_RD;
            end
          end
        end
        ST_REL_RD: state_r <= ST_REL_CHK;
        ST_REL_CHK: begin
          if (rd_valid) begin
            fv_r[rd_frame] <= 1'b0;
            if (cnt_cur != '0) cnt_r[cnt_idx] <= cnt_cur - 1'b1;
            o_phys_r <= '0;
            o_ev_r   <= 1'b1;
            o_vp_r   <= pid_r;
            o_vpg_r  <= pg_r;
            o_vf_r   <= 8'(rd_frame);
            o_last_r <= (cnt_cur <= CW'(1)) || (pg_r == PG_W'(PAGES_PER_PROCESS - 1));
            state_r  <= ST_OUT;
          end else if (pg_r == PG_W'(PAGES_PER_PROCESS - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            pg_r    <= pg_r + 1'b1;
            state_r <= ST_REL_RD;
          end
        end
        ST_LK_RD: state_r <= ST_LK_CHK;
        ST_LK_CHK: begin
          if (rd_valid) begin
            o_phys_r <= 10'({rd_frame, off_r});
            state_r  <= ST_OUT;
          end else begin
            o_fault_r <= 1'b1;
            fi_r      <= '0;
            state_r   <= ST_FS;
          end
        end
        ST_FS: begin
          if (!fv_r[fi_r]) begin
            f_r     <= fi_r;
            state_r <= ST_LOAD;
          end else if (fi_r == FW'(NUM_FRAMES - 1)) begin
            pi_r    <= '0;
            best_r  <= '0;
            bestp_r <= '0;
            state_r <= ST_MX;
          end else begin
            fi_r <= fi_r + 1'b1;
          end
        end
        ST_MX: begin
          if (cnt_cur > best_r) begin
            best_r  <= cnt_cur;
            bestp_r <= pi_r;
          end
          pi_r <= pi_r + 1'b1;
          if (pi_r == PID_W'(MAX_PROCESSES - 1)) begin
            pg_r   <= '0;
            have_r <= 1'b0;
            if ((cnt_cur > best_r) || (best_r != '0)) begin
              state_r <= ST_LR_RD;
            end else begin
              f_r     <= '0;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LR_RD: state_r <= ST_LR_CHK;
        ST_LR_CHK: begin
          logic take;
          take = rd_valid && (!have_r || (age > old_age_r));
          if (take) begin
            have_r    <= 1'b1;
            old_age_r <= age;
            old_pg_r  <= pg_r;
            old_fr_r  <= rd_frame;
          end
          pg_r <= pg_r + 1'b1;
          if (pg_r == PG_W'(PAGES_PER_PROCESS - 1)) begin
            if (have_r || take) begin
              state_r <= ST_EVICT;
            end else begin
              f_r     <= '0;
              state_r <= ST_LOAD;
            end
          end else begin
            state_r <= ST_LR_RD;
          end
        end
        ST_EVICT: begin
          fv_r[old_fr_r] <= 1'b0;
          if (cnt_cur != '0) cnt_r[cnt_idx] <= cnt_cur - 1'b1;
          o_ev_r  <= 1'b1;
          o_vp_r  <= bestp_r;
          o_vpg_r <= old_pg_r;
          o_vf_r  <= 8'(old_fr_r);
          f_r     <= old_fr_r;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          fv_r[f_r]      <= 1'b1;
          cnt_r[cnt_idx] <= cnt_cur + 1'b1;
          o_phys_r       <= 10'({f_r, off_r});
          state_r        <= ST_OUT;
        end
        ST_OUT: begin
          if (out_tready) begin
            if (rel_r && !o_last_r) begin
              pg_r    <= pg_r + 1'b1;
              state_r <= ST_REL_RD;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `AST_ALWAYS(a_no_overlap, !(in_tready && out_tvalid), "input taken while result pending")
  `AST_IMPL(a_load_free, state_r == ST_LOAD, !fv_r[f_r], "loading into an occupied frame")
  `AST_IMPL(a_evict_valid, state_r == ST_EVICT, fv_r[old_fr_r], "evicting a free frame")
endmodule
